// ===== sv/crcfr_pkg.sv =====
// Shared types, constants and CRC helper for the CRC-16 frame receiver.
package crcfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND = 8'hA5;
  localparam logic [7:0] CMD_READ   = 8'h83;
  localparam logic [7:0] CMD_WRITE  = 8'h82;
  localparam logic [7:0] ACK_O      = 8'h4F;
  localparam logic [7:0] ACK_K      = 8'h4B;
  localparam logic [7:0] OK_LEN     = 8'h05;
  localparam logic [7:0] POWER_ON   = 8'h00;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] KIND_POWER = 2'd0;
  localparam logic [1:0] KIND_TOUCH = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // data count per message, wide enough for the largest supported cap (64)
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {P_HUNT, P_HDR2, P_LEN, P_PAYLOAD} phase_t;
  typedef enum logic [1:0] {B_IDLE, B_READ, B_LOAD, B_SEND} back_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      addr;
    logic [7:0]       cnt;
    logic [CNT_W-1:0] n;
    logic [15:0]      ok;
  } job_t;

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== sv/crcfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== sv/crcfr_front.sv =====
// Byte parser: header hunt, CRC check, payload capture and message classification.
module crcfr_front #(
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [7:0]                        rx_byte,
  output logic                              in_stall,
  input  logic                              q_full,
  input  logic                              back_busy,
  output logic                              push,
  output crcfr_pkg::job_t                   job,
  output logic                              ram_we,
  output logic [$clog2(MAX_DATA_BYTES)-1:0] ram_waddr,
  output logic [7:0]                        ram_wdata
);
  import crcfr_pkg::*;

  localparam int AW = $clog2(MAX_DATA_BYTES);

  phase_t      phase, phase_next;
  logic [7:0]  length_byte;
  logic [8:0]  byte_index;
  logic [15:0] crc_accum;
  logic [15:0] received_crc;
  logic [15:0] ok_counter;
  logic [7:0]  cmd, addr_hi, addr_lo, cnt;

  logic        accept;
  logic        len_ok, is_chk, is_lo, frame_end, good, ok_frame;
  logic [7:0]  checked, avail;
  logic [15:0] rcv_new;
  logic [8:0]  want, n_a, n_b;

  // payload writes must not disturb a message still being read out
  assign in_stall = q_full || (phase == P_PAYLOAD && back_busy);
  assign accept   = in_valid && !in_stall;

  // frame bookkeeping
  always_comb begin
    checked   = length_byte - 8'd2;
    len_ok    = length_byte >= 8'd2;
    is_chk    = len_ok && (byte_index < {1'b0, checked});
    is_lo     = len_ok && (byte_index == {1'b0, checked});
    rcv_new   = received_crc;
    if (len_ok && !is_chk) begin
      if (is_lo) rcv_new[7:0] = rx_byte;
      else rcv_new[15:8] = rx_byte;
    end
    frame_end = ({1'b0, byte_index} + 10'd1) >= {2'b00, length_byte};
    good      = len_ok && (checked != 8'd0) && (crc_accum == rcv_new);
    ok_frame  = (length_byte == OK_LEN) && (cmd == CMD_WRITE) &&
                (addr_hi == ACK_O) && (addr_lo == ACK_K);
    avail     = (checked > 8'd4) ? checked - 8'd4 : 8'd0;
    want      = {cnt, 1'b0};
    n_a       = (want < {1'b0, avail}) ? want : {1'b0, avail};
    n_b       = (n_a > 9'(MAX_DATA_BYTES)) ? 9'(MAX_DATA_BYTES) : n_a;
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        P_HUNT:    if (rx_byte == HDR_FIRST) phase_next = P_HDR2;
        P_HDR2:    phase_next = (rx_byte == HDR_SECOND) ? P_LEN : P_HUNT;
        P_LEN:     phase_next = P_PAYLOAD;
        P_PAYLOAD: if (frame_end) phase_next = P_HUNT;
        default:   phase_next = P_HUNT;
      endcase
    end
  end

  always_comb begin
    push      = accept && ((phase == P_HUNT && rx_byte == POWER_ON) ||
                (phase == P_PAYLOAD && frame_end && good && !ok_frame && cmd == CMD_READ));
    job.ok    = ok_counter;
    if (phase == P_HUNT) begin
      job.kind = KIND_POWER;
      job.addr = 16'h0000;
      job.cnt  = 8'h00;
      job.n    = '0;
    end else begin
      job.kind = (cnt == 8'd1) ? KIND_TOUCH : KIND_READ;
      job.addr = {addr_hi, addr_lo};
      job.cnt  = cnt;
      job.n    = n_b[CNT_W-1:0];
    end
    ram_we    = accept && phase == P_PAYLOAD && is_chk && byte_index >= 9'd4 &&
                byte_index < 9'(4 + MAX_DATA_BYTES);
    ram_waddr = AW'(byte_index - 9'd4);
    ram_wdata = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_HUNT;
      length_byte  <= 8'h00;
      byte_index   <= 9'd0;
      crc_accum    <= CRC_INIT;
      received_crc <= 16'h0000;
      ok_counter   <= 16'h0000;
      cmd          <= 8'h00;
      addr_hi      <= 8'h00;
      addr_lo      <= 8'h00;
      cnt          <= 8'h00;
    end else begin
      phase <= phase_next;
      if (accept && phase == P_LEN) begin
        length_byte  <= rx_byte;
        byte_index   <= 9'd0;
        crc_accum    <= CRC_INIT;
        received_crc <= 16'h0000;
        cmd          <= 8'h00;
        addr_hi      <= 8'h00;
        addr_lo      <= 8'h00;
        cnt          <= 8'h00;
      end
      if (accept && phase == P_PAYLOAD) begin
        if (is_chk) begin
          crc_accum <= crc16_upd(crc_accum, rx_byte);
          unique case (byte_index)
            9'd0:    cmd     <= rx_byte;
            9'd1:    addr_hi <= rx_byte;
            9'd2:    addr_lo <= rx_byte;
            9'd3:    cnt     <= rx_byte;
            default: ;
          endcase
        end
        received_crc <= rcv_new;
        byte_index   <= byte_index + 9'd1;
        if (frame_end && good && ok_frame) ok_counter <= ok_counter + 16'd1;
      end
    end
  end

endmodule

// ===== sv/crcfr_queue.sv =====
// Two-entry message queue between parser and result sequencer.
module crcfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crcfr_pkg::job_t din,
  input  logic            pop,
  output crcfr_pkg::job_t dout,
  output logic            empty,
  output logic            full
);
  import crcfr_pkg::*;

  job_t       entry [2];
  logic       wp, rp;
  logic [1:0] count;

  assign dout  = entry[rp];
  assign empty = count == 2'd0;
  assign full  = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) entry[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/crcfr_back.sv =====
// Result sequencer: walks one message's data bytes out of the payload RAM.
module crcfr_back #(
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  crcfr_pkg::job_t                   q_head,
  output logic                              pop,
  output logic                              active,
  output logic                              ram_re,
  output logic [$clog2(MAX_DATA_BYTES)-1:0] ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [15:0]                       var_addr,
  output logic [7:0]                        word_count,
  output logic [7:0]                        data_byte,
  output logic [4:0]                        byte_position,
  output logic                              data_valid,
  output logic                              last,
  output logic [15:0]                       ok_frames
);
  import crcfr_pkg::*;

  localparam int AW = $clog2(MAX_DATA_BYTES);

  back_t            state, state_next;
  job_t             job_r;
  logic [CNT_W-1:0] idx;
  logic [7:0]       data_r;
  logic [4:0]       pos_r;
  logic             dv_r, last_r;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = (q_head.n == '0) ? B_SEND : B_READ;
      B_READ: state_next = B_LOAD;
      B_LOAD: state_next = B_SEND;
      B_SEND: if (!out_stall) state_next = last_r ? B_IDLE : B_READ;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == B_IDLE) && !q_empty;
    active    = state != B_IDLE;
    ram_re    = state == B_READ;
    ram_raddr = idx[AW-1:0];
    out_valid = state == B_SEND;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= q_head;
      idx    <= '0;
      data_r <= 8'h00;
      pos_r  <= 5'd0;
      dv_r   <= 1'b0;
      last_r <= 1'b1;   // no-data message: a single marker beat
    end
    if (state == B_LOAD) begin
      data_r <= ram_rdata;
      pos_r  <= idx[4:0];
      dv_r   <= 1'b1;
      last_r <= (idx + CNT_W'(1)) == job_r.n;
    end
    if (state == B_SEND && !out_stall) idx <= idx + CNT_W'(1);
  end

  assign kind          = job_r.kind;
  assign var_addr      = job_r.addr;
  assign word_count    = job_r.cnt;
  assign ok_frames     = job_r.ok;
  assign data_byte     = data_r;
  assign byte_position = pos_r;
  assign data_valid    = dv_r;
  assign last          = last_r;

endmodule

// ===== sv/crc16_frame_receiver.sv =====
// A message's first result is valid once the message has passed the queue, a pop, a RAM
// read and a load; a power-on or other no-data beat is popped and sent with no RAM read.
// Throughput: one byte per cycle while hunting or parsing and in_stall is low; a message is
// a pop, then RAM read, load, send per beat. Payload bytes of the next frame stall while an
// earlier message is still read out. Reset (rst, synchronous): parser hunts for a header,
// queue empties, OK count is zero; the payload RAM is not cleared.
module crc16_frame_receiver #(
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] var_addr,
  output logic [7:0]  word_count,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_position,
  output logic        data_valid,
  output logic        last,
  output logic [15:0] ok_frames
);
  import crcfr_pkg::*;

  localparam int AW = $clog2(MAX_DATA_BYTES);

  job_t          push_job, head_job;
  logic          push, pop, q_empty, q_full, back_active, back_busy;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign back_busy = !q_empty || back_active;

  crcfr_front #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_front (
    .clk, .rst, .in_valid, .rx_byte, .in_stall,
    .q_full, .back_busy,
    .push, .job(push_job),
    .ram_we, .ram_waddr, .ram_wdata
  );

  crcfr_queue u_queue (
    .clk, .rst, .push, .din(push_job), .pop, .dout(head_job),
    .empty(q_empty), .full(q_full)
  );

  crcfr_ram #(.WIDTH(8), .DEPTH(MAX_DATA_BYTES)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  crcfr_back #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_back (
    .clk, .rst, .q_empty, .q_head(head_job), .pop, .active(back_active),
    .ram_re, .ram_raddr, .ram_rdata,
    .out_valid, .out_stall, .kind, .var_addr, .word_count, .data_byte,
    .byte_position, .data_valid, .last, .ok_frames
  );

endmodule

// ===== sv/crcfr_checker.sv =====
// Port-level assertions for the frame receiver, bound to the top level.
module crcfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [15:0] var_addr,
  input logic [7:0]  word_count,
  input logic [7:0]  data_byte,
  input logic [4:0]  byte_position,
  input logic        data_valid,
  input logic        last
);
  import crcfr_pkg::*;

  // held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(byte_position) &&
    $stable(last) && $stable(var_addr))
    else $error("result beat changed while stalled");

  // a beat without data is always the only one of its message
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> last && data_byte == 8'h00 && byte_position == 5'd0)
    else $error("no-data beat not marked last or not zeroed");

  a_power: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_POWER |-> var_addr == 16'h0000 && word_count == 8'h00 &&
    !data_valid)
    else $error("power-on beat carries frame fields");

  // touch messages carry at most two data bytes
  a_touch: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TOUCH && data_valid |-> byte_position == 5'd0 ||
    byte_position == 5'd1)
    else $error("touch message beyond two data bytes");

endmodule

bind crc16_frame_receiver crcfr_checker u_checker (.*);

// ===== dv/tb_crc16_frame_receiver.sv =====
// Self-checking testbench for the CRC-16 frame receiver: byte stimulus, scoreboard, checks.
`timescale 1ns / 1ps

import crcfr_pkg::*;

localparam int DATA_CAP    = 32;
localparam int STORE_DEPTH = 4 + DATA_CAP;

typedef struct packed {
  logic [1:0]  kind;
  logic [15:0] addr;
  logic [7:0]  cnt;
  logic [7:0]  data;
  logic [4:0]  pos;
  logic        dv;
  logic        last;
  logic [15:0] ok;
} msg_result_t;

// CRC-16/MODBUS over one byte, LSB first
function automatic logic [15:0] modbus_crc_byte(logic [15:0] acc, logic [7:0] b);
  logic [15:0] r;
  r = acc ^ {8'h00, b};
  repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
  return r;
endfunction

class frame_checker;
  phase_t      phase;
  logic [7:0]  len;
  int          idx;
  logic [15:0] crc;
  logic [15:0] rx_crc;
  logic [15:0] okc;
  logic [7:0]  store [STORE_DEPTH];
  msg_result_t pending [$];
  int          errors;

  function new();
    phase  = P_HUNT;
    len    = 8'h00;
    idx    = 0;
    crc    = CRC_INIT;
    rx_crc = 16'h0000;
    okc    = 16'h0000;
    errors = 0;
  endfunction

  function logic [7:0] field_at(int i, int checked);
    if (i < checked && i < STORE_DEPTH) return store[i];
    return 8'h00;
  endfunction

  function void push(logic [1:0] k, logic [15:0] a, logic [7:0] c, logic [7:0] d,
                     logic [4:0] p, logic dv, logic lst);
    msg_result_t r;
    r.kind = k;
    r.addr = a;
    r.cnt  = c;
    r.data = d;
    r.pos  = p;
    r.dv   = dv;
    r.last = lst;
    r.ok   = okc;
    pending.push_back(r);
  endfunction

  function void close_frame();
    int          checked;
    int          want;
    int          avail;
    int          n;
    logic [7:0]  cmd;
    logic [7:0]  cnt;
    logic [15:0] addr;
    logic [1:0]  k;
    if (len < 2 || crc != rx_crc) return;
    checked = len - 2;
    if (checked == 0) return;
    cmd = store[0];
    if (len == OK_LEN && cmd == CMD_WRITE && field_at(1, checked) == ACK_O &&
        field_at(2, checked) == ACK_K) begin
      okc = okc + 16'd1;
      return;
    end
    if (cmd != CMD_READ) return;
    addr  = {field_at(1, checked), field_at(2, checked)};
    cnt   = field_at(3, checked);
    k     = (cnt == 8'd1) ? KIND_TOUCH : KIND_READ;
    want  = 2 * int'(cnt);
    avail = (checked > 4) ? checked - 4 : 0;
    n     = (want < avail) ? want : avail;
    if (n > DATA_CAP) n = DATA_CAP;
    if (n == 0) begin
      push(k, addr, cnt, 8'h00, 5'd0, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++)
      push(k, addr, cnt, field_at(4 + i, checked), i[4:0], 1'b1, (i + 1 == n));
  endfunction

  function void take_byte(logic [7:0] b);
    int pos;
    case (phase)
      P_HUNT: begin
        if (b == HDR_FIRST) phase = P_HDR2;
        else if (b == POWER_ON) push(KIND_POWER, 16'h0, 8'h0, 8'h0, 5'd0, 1'b0, 1'b1);
      end
      P_HDR2: begin
        if (b == HDR_SECOND) phase = P_LEN;
        else phase = P_HUNT;
      end
      P_LEN: begin
        len    = b;
        idx    = 0;
        crc    = CRC_INIT;
        rx_crc = 16'h0000;
        phase  = P_PAYLOAD;
      end
      default: begin
        pos = idx;
        if (len >= 2 && pos < len - 2) begin
          crc = modbus_crc_byte(crc, b);
          if (pos < STORE_DEPTH) store[pos] = b;
        end else if (len >= 2 && pos == len - 2) begin
          rx_crc[7:0] = b;
        end else if (len >= 2) begin
          rx_crc[15:8] = b;
        end
        idx = (pos + 1) % 512;
        if (pos + 1 >= len) begin
          close_frame();
          phase = P_HUNT;
        end
      end
    endcase
  endfunction

  function void cmp(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  function void check_msg(msg_result_t got);
    msg_result_t exp;
    if (pending.size() == 0) begin
      $display("%0t unexpected result: expected none actual kind %0d addr %h data %h",
               $time, got.kind, got.addr, got.data);
      errors++;
      return;
    end
    exp = pending.pop_front();
    cmp("kind", exp.kind, got.kind);
    cmp("var_addr", exp.addr, got.addr);
    cmp("word_count", exp.cnt, got.cnt);
    cmp("data_byte", exp.data, got.data);
    cmp("byte_position", exp.pos, got.pos);
    cmp("data_valid", exp.dv, got.dv);
    cmp("last", exp.last, got.last);
    cmp("ok_frames", exp.ok, got.ok);
  endfunction
endclass

module tb_crc16_frame_receiver;

  localparam int LIMIT       = 3000000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_ITEMS     = 420;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] var_addr;
  logic [7:0]  word_count;
  logic [7:0]  data_byte;
  logic [4:0]  byte_position;
  logic        data_valid;
  logic        last;
  logic [15:0] ok_frames;

  frame_checker frame_chk = new();
  logic [7:0]   body_q [$];
  int           sent_items = 0;
  int           cycle_cnt = 0;
  bit           pace_on = 1'b0;
  int           gap_max = 1;
  int           burst_left = 0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           mode_left = 0;
  int           stall_mode = 0;

  crc16_frame_receiver #(.MAX_DATA_BYTES(DATA_CAP)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .var_addr(var_addr), .word_count(word_count),
    .data_byte(data_byte), .byte_position(byte_position),
    .data_valid(data_valid), .last(last), .ok_frames(ok_frames)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) frame_chk.take_byte(rx_byte);
      if (out_valid && !out_stall)
        frame_chk.check_msg({kind, var_addr, word_count, data_byte, byte_position,
                             data_valid, last, ok_frames});
    end
  end

  // receiver back-pressure: long hold on request, otherwise a drifting pattern
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= mode_left[2];
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (pace_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, gap_max);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // header, length, body_q, CRC low then high
  task automatic send_frame(input bit bad_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body_q[i]) c = modbus_crc_byte(c, body_q[i]);
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'(body_q.size() + 2));
    foreach (body_q[i]) send_byte(body_q[i]);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  function automatic void build_read(logic [15:0] addr, logic [7:0] cnt, int ndata);
    body_q.delete();
    body_q.push_back(CMD_READ);
    body_q.push_back(addr[15:8]);
    body_q.push_back(addr[7:0]);
    body_q.push_back(cnt);
    repeat (ndata) body_q.push_back(8'($urandom));
  endfunction

  function automatic void build_ok();
    body_q.delete();
    body_q.push_back(CMD_WRITE);
    body_q.push_back(ACK_O);
    body_q.push_back(ACK_K);
  endfunction

  initial begin
    int          sel;
    int          nd;
    logic [7:0]  cnt;
    logic [7:0]  b;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    send_byte(POWER_ON);
    send_byte(HDR_FIRST);
    send_byte(POWER_ON);               // bad second header, not re-examined
    send_byte(8'h37);                  // ignored while hunting
    send_byte(POWER_ON);
    send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(8'h00); send_byte(POWER_ON);
    send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(8'h01); send_byte(8'hFF);
    body_q.delete();
    send_frame(1'b0);                  // length 2, nothing checked
    build_ok();
    send_frame(1'b0);
    send_frame(1'b1);                  // OK frame with bad CRC does not count
    send_byte(POWER_ON);
    build_read(16'h1234, 8'd1, 2);
    send_frame(1'b0);
    build_read(16'h0000, 8'h10, 32);
    send_frame(1'b0);
    build_read(16'hFFFF, 8'hFF, 40);   // data capped
    send_frame(1'b0);
    build_read(16'h8001, 8'd3, 2);     // clipped to bytes received
    send_frame(1'b0);
    build_read(16'h00FF, 8'd0, 5);     // word count zero
    send_frame(1'b0);
    build_read(16'h5AA5, 8'd1, 0);     // touch with no data
    send_frame(1'b0);
    body_q = {CMD_READ};               // header fields missing
    send_frame(1'b0);
    body_q = {CMD_READ, 8'h12};
    send_frame(1'b0);
    body_q = {CMD_READ, 8'hAB, 8'hCD};
    send_frame(1'b0);
    build_read(16'h4321, 8'd4, 8);
    send_frame(1'b1);
    body_q = {8'h10, 8'h00, 8'h01, 8'h02};
    send_frame(1'b0);                  // unknown command
    body_q = {CMD_WRITE, ACK_O, ACK_K, 8'h00};
    send_frame(1'b0);                  // OK body but wrong length
    body_q = {CMD_WRITE, ACK_O, 8'h00};
    send_frame(1'b0);
    send_byte(POWER_ON);

    // receiver holds off while full-size messages keep coming
    hold_req = 1'b1;
    repeat (2) begin
      build_read(16'($urandom), 8'h10, 32);
      send_frame(1'b0);
    end

    // random part
    while (sent_items < N_ITEMS) begin
      pace_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: gap_max = 1;
        1: gap_max = 2;
        2: gap_max = 4;
        default: gap_max = 10;
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        case ($urandom_range(0, 4))
          0: cnt = 8'd1;
          1: cnt = 8'($urandom);
          default: cnt = 8'($urandom_range(0, 20));
        endcase
        nd = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
        build_read(16'($urandom), cnt, nd);
        send_frame($urandom_range(0, 9) == 0);
      end else if (sel < 63) begin
        build_ok();
        send_frame($urandom_range(0, 9) == 0);
      end else if (sel < 70) begin
        body_q = {CMD_READ};
        repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom));
        send_frame(1'b0);
      end else if (sel < 76) begin
        body_q.delete();
        do b = 8'($urandom); while (b == CMD_READ || b == CMD_WRITE);
        body_q.push_back(b);
        repeat ($urandom_range(0, 9)) body_q.push_back(8'($urandom));
        send_frame(1'b0);
      end else if (sel < 84) begin
        send_byte(POWER_ON);
      end else if (sel < 90) begin
        b = 8'($urandom);
        send_byte(b);
      end else if (sel < 95) begin
        send_byte(HDR_FIRST);
        send_byte(8'($urandom));
      end else begin
        nd = $urandom_range(0, 2);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'(nd));
        repeat ((nd == 2) ? 2 : 1) send_byte(8'($urandom));
      end
    end
    release_input();

    while (frame_chk.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (frame_chk.errors == 0 && frame_chk.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/crcfr_pkg.sv
sv/crcfr_ram.sv
sv/crcfr_front.sv
sv/crcfr_queue.sv
sv/crcfr_back.sv
sv/crc16_frame_receiver.sv
sv/crcfr_checker.sv
dv/tb_crc16_frame_receiver.sv
